[rtl/backslash_escape_decoder_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the backslash escape decoder
// Implication checks for the same cycle and for the next cycle. They compile
// to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// ante holds at an edge, so cons holds at the same edge
`define BED_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// ante holds at an edge, so cons holds at the next edge
`define BED_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define BED_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BED_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/bed_pkg.sv]
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Character codes, decoder state and the per-transaction decode result.
// ----------------------------------------------------------------------------
package bed_pkg;

   localparam logic [7:0] BACKSLASH       = 8'h5C;
   localparam logic [7:0] CHAR_N          = 8'h6E;
   localparam logic [7:0] CHAR_R          = 8'h72;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_THREE      = 8'h33;
   localparam logic [7:0] CHAR_SEVEN      = 8'h37;
   localparam logic [7:0] LINE_FEED       = 8'h0A;
   localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
   localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;
   localparam logic [1:0] MAX_BYTES        = 2'd3;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_OCT  = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  oct_value;
      logic [1:0]  oct_digits;
   } state_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;   // bytes[0] goes out first
      logic [1:0]      count;
      state_type       nxt;
   } decode_type;

endpackage

[rtl/bed_decode.sv]
// ----------------------------------------------------------------------------
// Backslash escape decoder, byte decode
// Maps the current state and one input byte to up to three output bytes
// and the next state.
// ----------------------------------------------------------------------------
module bed_decode (
   input  bed_pkg::state_type  state,
   input  logic [7:0]          in_byte,
   input  logic                end_of_string,
   output bed_pkg::decode_type result
);
   import bed_pkg::*;

   function automatic decode_type put_byte(decode_type d, logic [7:0] b);
      if (d.count < MAX_BYTES) begin
         d.bytes[d.count] = b;
         d.count = d.count + 2'd1;
      end
      return d;
   endfunction

   // backslash opens an escape, anything else goes straight out
   function automatic decode_type plain_byte(decode_type d, logic [7:0] b);
      if (b == BACKSLASH) begin
         d.nxt.mode = MODE_ESC;
      end else begin
         d = put_byte(d, b);
      end
      return d;
   endfunction

   // zero value stays escaped as backslash, '0'
   function automatic decode_type flush_octal(decode_type d);
      if (d.nxt.oct_value != 8'h00) begin
         d = put_byte(d, d.nxt.oct_value);
      end else begin
         d = put_byte(d, BACKSLASH);
         d = put_byte(d, CHAR_ZERO);
      end
      d.nxt.mode = MODE_TEXT;
      d.nxt.oct_value = 8'h00;
      d.nxt.oct_digits = 2'd0;
      return d;
   endfunction

   always_comb begin
      decode_type d;
      d = '0;
      d.nxt = state;
      case (state.mode)
         MODE_ESC: begin
            d.nxt.mode = MODE_TEXT;
            if (in_byte == CHAR_N) begin
               d = put_byte(d, LINE_FEED);
            end else if (in_byte == CHAR_R) begin
               d = put_byte(d, CARRIAGE_RETURN);
            end else if (in_byte == BACKSLASH) begin
               d = put_byte(d, BACKSLASH);
            end else if (in_byte inside {[CHAR_ZERO:CHAR_THREE]}) begin
               d.nxt.mode = MODE_OCT;
               d.nxt.oct_value = {5'd0, in_byte[2:0]};
               d.nxt.oct_digits = 2'd1;
            end else begin
               d = put_byte(d, BACKSLASH);
               d = plain_byte(d, in_byte);
            end
         end
         MODE_OCT: begin
            if ((in_byte inside {[CHAR_ZERO:CHAR_SEVEN]}) &&
                (state.oct_digits < OCTAL_MAX_DIGITS)) begin
               d.nxt.oct_value = {state.oct_value[4:0], in_byte[2:0]};
               d.nxt.oct_digits = state.oct_digits + 2'd1;
               if (d.nxt.oct_digits >= OCTAL_MAX_DIGITS) begin
                  d = flush_octal(d);
               end
            end else begin
               d = flush_octal(d);
               d = plain_byte(d, in_byte);
            end
         end
         default: begin
            d.nxt.mode = MODE_TEXT;
            d = plain_byte(d, in_byte);
         end
      endcase

      // string end: flush whatever escape is still open
      if (end_of_string) begin
         if (d.nxt.mode == MODE_ESC) begin
            d = put_byte(d, BACKSLASH);
         end else if (d.nxt.mode == MODE_OCT) begin
            d = flush_octal(d);
         end
         d.nxt.mode = MODE_TEXT;
         d.nxt.oct_value = 8'h00;
         d.nxt.oct_digits = 2'd0;
      end
      result = d;
   end

endmodule

[rtl/backslash_escape_decoder.sv]
// ----------------------------------------------------------------------------
// Backslash escape decoder
// Unescapes a C-style string one byte per transaction.
//
// Request channel (req_): one escaped byte per transaction, with
// req_end_of_string high on the final byte of a string. Response channel
// (rsp_): one unescaped byte per transaction, rsp_last_out high on the final
// byte of a string. Both are valid/ready.
// Each accepted request is decoded in the accept cycle and its bytes (zero
// to three) land in a three-byte output register; the first one shows on
// rsp_ the next cycle. The register drains one byte a cycle while rsp_ready
// is high; a request making two or three bytes holds the request side until
// its last byte is taken. Requests making no bytes are taken every cycle and
// those making one byte every cycle while rsp_ready is high. req_ready stays
// high while the last buffered byte is taken, so no bubble appears between
// items. A stall holds the buffered bytes and drops req_ready while any remain.
// Reset clears the decode state to plain text and empties the buffer.
// ----------------------------------------------------------------------------
`include "backslash_escape_decoder_macros.svh"

module backslash_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_out
);
   import bed_pkg::*;

   // decode state carried between transactions
   state_type       state_ff, state_in;
   // output buffer: byte 0 is at the head, shifts down on each take
   logic [2:0][7:0] buf_ff, buf_in;
   logic [1:0]      rem_ff, rem_in;     // bytes still to deliver
   logic            last_ff, last_in;   // buffered item closes its string

   decode_type      dec;
   logic            req_accept;
   logic            rsp_take;

   bed_decode u_decode (
      .state         (state_ff),
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .result        (dec)
   );

   assign rsp_valid    = (rem_ff != 2'd0);
   assign rsp_out_byte = buf_ff[0];
   assign rsp_last_out = last_ff && (rem_ff == 2'd1);

   // take a new item when the buffer is empty or its last byte leaves now
   assign req_ready  = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign rsp_take   = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      rem_in   = rem_ff;
      last_in  = last_ff;
      if (req_accept) begin
         state_in = dec.nxt;
         buf_in   = dec.bytes;
         rem_in   = dec.count;
         last_in  = req_end_of_string;
      end else if (rsp_take) begin
         buf_in = {8'h00, buf_ff[2], buf_ff[1]};
         rem_in = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_TEXT, oct_value: 8'h00, oct_digits: 2'd0};
         rem_ff   <= 2'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   // an item that makes bytes shows its first byte next cycle
   `BED_ASSERT_NEXT(a_bytes_follow, clock, reset,
                    req_accept && (dec.count != 2'd0), rsp_valid)
   // more than one byte left means the request side is held
   `BED_ASSERT_IMPL(a_hold_when_busy, clock, reset,
                    rem_ff > 2'd1, !req_ready)
   // end of string leaves no escape open
   `BED_ASSERT_NEXT(a_eos_clears, clock, reset,
                    req_accept && req_end_of_string,
                    (state_ff.mode == MODE_TEXT) && (state_ff.oct_digits == 2'd0))
   // an open octal escape has one or two digits in hand
   `BED_ASSERT_IMPL(a_oct_digits, clock, reset,
                    state_ff.mode == MODE_OCT,
                    (state_ff.oct_digits == 2'd1) || (state_ff.oct_digits == 2'd2))

endmodule

[tb/backslash_escape_decoder_test.sv]
// ----------------------------------------------------------------------------
// Backslash escape decoder testbench
// Feeds escaped strings one byte per transaction. A directed table covers
// every escape kind and the string-end flushes, then random strings built
// mostly from well-formed escapes follow. Every decoded byte is checked, with
// random idle bursts on both channels, against the bytes written in a typed table row or else an in-bench unescaper.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bed_pkg::*;

   localparam int ITEM_TARGET = 460;   // total escaped bytes to send
   localparam int QUIET_TAIL  = 60;    // last bytes sent with no idling

   // one decoded byte as it should leave the block
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_char_type;

   // directed table row; typed rows carry the decoded bytes written out
   typedef struct packed {
      logic [7:0]      data;
      logic            eos;
      logic            typed;
      logic [1:0]      n;
      logic [2:0][7:0] chars;   // chars[0] comes out first
   } text_row_type;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte       = 8'h20;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_out;

   backslash_escape_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_out      (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Unescaper: mirrors the decode state and queues the bytes each
   // transaction should produce.
   // --------------------------------------------------------------------------
   mode_type           esc_mode  = MODE_TEXT;
   logic [7:0]         oct_acc   = 8'h00;
   logic [1:0]         oct_count = 2'd0;
   logic [7:0]         out_buf [3];
   int                 out_n;
   decoded_char_type   expected_chars [$];

   int mismatches    = 0;
   int chars_checked = 0;
   int bytes_sent    = 0;
   int strings_sent  = 0;
   bit idle_enable   = 1'b1;
   int stall_left    = 0;

   function automatic void emit_char(input logic [7:0] c);
      if (out_n < 3) begin
         out_buf[out_n] = c;
         out_n++;
      end
   endfunction

   // all-zero escapes come out as the two bytes backslash, '0'
   function automatic void close_octal();
      if (oct_acc != 8'h00) begin
         emit_char(oct_acc);
      end else begin
         emit_char(BACKSLASH);
         emit_char(CHAR_ZERO);
      end
      esc_mode  = MODE_TEXT;
      oct_acc   = 8'h00;
      oct_count = 2'd0;
   endfunction

   function automatic void text_char(input logic [7:0] c);
      if (c == BACKSLASH) esc_mode = MODE_ESC;
      else emit_char(c);
   endfunction

   function automatic void unescape_byte(input logic [7:0] c, input logic eos,
                                         input bit keep);
      out_n = 0;
      case (esc_mode)
         MODE_ESC: begin
            esc_mode = MODE_TEXT;
            if (c == CHAR_N) emit_char(LINE_FEED);
            else if (c == CHAR_R) emit_char(CARRIAGE_RETURN);
            else if (c == BACKSLASH) emit_char(BACKSLASH);
            else if (c >= CHAR_ZERO && c <= CHAR_THREE) begin
               esc_mode  = MODE_OCT;
               oct_acc   = c - CHAR_ZERO;
               oct_count = 2'd1;
            end else begin
               // unknown escape: backslash out, byte handled as text
               emit_char(BACKSLASH);
               text_char(c);
            end
         end
         MODE_OCT: begin
            if (c >= CHAR_ZERO && c <= CHAR_SEVEN && oct_count < OCTAL_MAX_DIGITS) begin
               oct_acc   = (oct_acc << 3) + (c - CHAR_ZERO);
               oct_count = oct_count + 2'd1;
               if (oct_count >= OCTAL_MAX_DIGITS) close_octal();
            end else begin
               // escape ends early; the byte is handled as text after it
               close_octal();
               text_char(c);
            end
         end
         default: begin
            esc_mode = MODE_TEXT;
            text_char(c);
         end
      endcase
      if (eos) begin
         // flush whatever escape is still open
         if (esc_mode == MODE_ESC) emit_char(BACKSLASH);
         else if (esc_mode == MODE_OCT) close_octal();
         esc_mode  = MODE_TEXT;
         oct_acc   = 8'h00;
         oct_count = 2'd0;
      end
      if (keep) begin
         for (int i = 0; i < out_n; i++) begin
            expected_chars.push_back('{out_buf[i], eos && (i == out_n - 1)});
         end
      end
   endfunction

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------
   task automatic drive_byte(input logic [7:0] c, input logic eos);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= c;
      req_end_of_string <= eos;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (eos) strings_sent++;
   endtask

   // --------------------------------------------------------------------------
   // Response side: ready with random stall bursts, checker on each
   // accepted transaction.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 18) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      decoded_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected decoded byte %h (last_out %b)", rsp_out_byte, rsp_last_out);
            mismatches++;
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %h, got %h", want.data, rsp_out_byte);
               mismatches++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out: expected %b, got %b", want.last, rsp_last_out);
               mismatches++;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Directed table
   // --------------------------------------------------------------------------
   text_row_type dir_rows [26] = '{
      '{8'hFF,      1'b0, 1'b1, 2'd1, {16'h0000, 8'hFF}},        // first byte after reset, top value
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},
      '{CHAR_N,     1'b0, 1'b0, 2'd0, 24'h0},                    // newline
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},
      '{CHAR_R,     1'b0, 1'b0, 2'd0, 24'h0},                    // carriage return
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},                    // double backslash
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},
      '{8'h31,      1'b0, 1'b0, 2'd0, 24'h0},
      '{8'h30,      1'b0, 1'b0, 2'd0, 24'h0},
      '{8'h31,      1'b0, 1'b0, 2'd0, 24'h0},                    // third digit closes octal
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},
      '{CHAR_ZERO,  1'b0, 1'b0, 2'd0, 24'h0},
      '{8'h38,      1'b0, 1'b0, 2'd0, 24'h0},                    // '8' ends a zero escape
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},
      '{8'h71,      1'b0, 1'b0, 2'd0, 24'h0},                    // unknown escape
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},
      '{CHAR_THREE, 1'b0, 1'b0, 2'd0, 24'h0},
      '{CHAR_SEVEN, 1'b0, 1'b0, 2'd0, 24'h0},
      '{CHAR_SEVEN, 1'b0, 1'b1, 2'd1, {16'h0000, 8'hFF}},        // largest octal value
      '{BACKSLASH,  1'b1, 1'b1, 2'd1, {16'h0000, BACKSLASH}},    // trailing backslash
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},
      '{8'h32,      1'b1, 1'b1, 2'd1, {16'h0000, 8'h02}},        // open octal at string end
      '{BACKSLASH,  1'b0, 1'b0, 2'd0, 24'h0},
      '{CHAR_ZERO,  1'b0, 1'b0, 2'd0, 24'h0},
      '{CHAR_ZERO,  1'b1, 1'b1, 2'd2, {8'h00, CHAR_ZERO, BACKSLASH}}  // zero octal at end
   };

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      logic [7:0] str_q [$];
      int         n_seg;
      int         n_dig;
      bit         all_zero;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         drive_byte(dir_rows[i].data, dir_rows[i].eos);
         if (dir_rows[i].typed) begin
            for (int k = 0; k < dir_rows[i].n; k++) begin
               expected_chars.push_back('{dir_rows[i].chars[k],
                                          dir_rows[i].eos && (k == dir_rows[i].n - 1)});
            end
            unescape_byte(dir_rows[i].data, dir_rows[i].eos, 1'b0);
         end else begin
            unescape_byte(dir_rows[i].data, dir_rows[i].eos, 1'b1);
         end
      end

      // random strings, mostly well-formed escapes with random content
      while (bytes_sent < ITEM_TARGET) begin
         str_q.delete();
         n_seg = $urandom_range(1, 8);
         for (int s = 0; s < n_seg; s++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: str_q.push_back(8'($urandom_range(1, 255)));
               3: begin str_q.push_back(BACKSLASH); str_q.push_back(CHAR_N); end
               4: begin str_q.push_back(BACKSLASH); str_q.push_back(CHAR_R); end
               5: begin str_q.push_back(BACKSLASH); str_q.push_back(BACKSLASH); end
               6, 7: begin
                  // octal escape, one to three digits, often all zero
                  all_zero = ($urandom_range(0, 2) == 0);
                  n_dig    = $urandom_range(1, 3);
                  str_q.push_back(BACKSLASH);
                  str_q.push_back(all_zero ? CHAR_ZERO : CHAR_ZERO + 8'($urandom_range(0, 3)));
                  for (int d = 1; d < n_dig; d++) begin
                     str_q.push_back(all_zero ? CHAR_ZERO
                                              : CHAR_ZERO + 8'($urandom_range(0, 7)));
                  end
               end
               8: begin
                  str_q.push_back(BACKSLASH);
                  str_q.push_back(8'($urandom_range(1, 255)));
               end
               default: begin
                  // noise: digits and stray backslashes
                  if ($urandom_range(0, 2) == 0) str_q.push_back(BACKSLASH);
                  else str_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
               end
            endcase
         end
         if ($urandom_range(0, 4) == 0) str_q.push_back(BACKSLASH);

         // idling on most strings, none in the tail
         if (bytes_sent >= ITEM_TARGET - QUIET_TAIL) idle_enable = 1'b0;
         else idle_enable = ($urandom_range(0, 3) != 0);

         foreach (str_q[j]) begin
            drive_byte(str_q[j], j == str_q.size() - 1);
            unescape_byte(str_q[j], j == str_q.size() - 1, 1'b1);
         end
      end
      req_valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d escaped bytes in %0d strings (directed table plus random escapes).",
               bytes_sent, strings_sent);
      $display("Checked %0d decoded bytes, %0d mismatches.", chars_checked, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[backslash_escape_decoder.f]
+incdir+rtl
rtl/bed_pkg.sv
rtl/bed_decode.sv
rtl/backslash_escape_decoder.sv
tb/backslash_escape_decoder_test.sv
